### design/json_vocab_entry_scanner_defines.svh
// Assertion macros shared by the checker of the vocabulary entry scanner.
// Each macro expects signals named clk and arst_n in the using scope.
`ifndef JSON_VOCAB_ENTRY_SCANNER_DEFINES_SVH
`define JSON_VOCAB_ENTRY_SCANNER_DEFINES_SVH

// Same-cycle implication, checked only while out of reset.
`define JVES_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scanner check failed");

// Next-cycle implication, checked only while out of reset.
`define JVES_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scanner check failed");

`endif

### design/jves_pkg.sv
// Shared types and constants of the JSON vocabulary entry scanner.
// No dependencies; used by the controller, the datapath and the top level.
package jves_pkg;

	// Character codes recognised by the parser.
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	// Length of the quoted word "vocab", quotes included.
	localparam logic [2:0] VOCAB_LEN = 3'd7;

	// Id text states.
	localparam logic [2:0] ID_EMPTY  = 3'd0;
	localparam logic [2:0] ID_SIGN   = 3'd1;
	localparam logic [2:0] ID_DIGITS = 3'd2;
	localparam logic [2:0] ID_ENDED  = 3'd3;
	localparam logic [2:0] ID_BAD    = 3'd4;

	// Largest id before a further digit overflows 64 bits, and the largest last digit.
	localparam logic [63:0] ID_MAX_DIV10 = 64'd1844674407370955161;
	localparam logic [3:0]  ID_MAX_MOD10 = 4'd5;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic take;        // an input request is accepted this cycle
		logic clr;         // that request starts a new document
		logic seek_key;    // byte is matched against the quoted word
		logic seek_brace;  // byte is checked for the opening brace
		logic object;      // byte is parsed inside the object
		logic emit;        // a token run is being sent
		logic emit_adv;    // the current output request is taken
	} jves_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic vocab_hit;   // quoted word completed
		logic brace_hit;   // opening brace found
		logic fire;        // a valid entry ends here
		logic obj_end;     // depth has returned to zero
		logic emit_last;   // output byte is the final one of its run
	} jves_sts_t;

	function automatic logic [7:0] vocab_char(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0: c = CH_QUOTE;
			3'd1: c = 8'h76;
			3'd2: c = 8'h6F;
			3'd3: c = 8'h63;
			3'd4: c = 8'h61;
			3'd5: c = 8'h62;
			3'd6: c = CH_QUOTE;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

### design/jves_ctrl.sv
// Controller of the JSON vocabulary entry scanner: parse phase and token emission.
// Depends on jves_pkg for the command and status structs.
module jves_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_start,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  jves_pkg::jves_sts_t sts,
	output jves_pkg::jves_cmd_t cmd
);

	localparam logic [2:0] ST_SEEK_KEY   = 3'd0;
	localparam logic [2:0] ST_SEEK_BRACE = 3'd1;
	localparam logic [2:0] ST_OBJECT     = 3'd2;
	localparam logic [2:0] ST_DONE       = 3'd3;
	localparam logic [2:0] ST_EMIT       = 3'd4;
	localparam logic [2:0] ST_EMIT_DONE  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic [2:0] eff_state;
	logic       emitting;
	logic       take;

	assign emitting  = (state_q == ST_EMIT) || (state_q == ST_EMIT_DONE);
	assign in_ready  = !emitting;
	assign out_valid = emitting;
	assign take      = in_valid && !emitting;
	// A new document restarts the search on its first byte.
	assign eff_state = (take && in_start) ? ST_SEEK_KEY : state_q;

	always_comb begin
		cmd.take       = take;
		cmd.clr        = take && in_start;
		cmd.seek_key   = take && (eff_state == ST_SEEK_KEY);
		cmd.seek_brace = take && (eff_state == ST_SEEK_BRACE);
		cmd.object     = take && (eff_state == ST_OBJECT);
		cmd.emit       = emitting;
		cmd.emit_adv   = emitting && out_ready;
	end

	always_comb begin
		state_d = state_q;
		if (emitting) begin
			if (out_ready && sts.emit_last) begin
				state_d = (state_q == ST_EMIT_DONE) ? ST_DONE : ST_OBJECT;
			end
		end else if (take) begin
			case (eff_state)
				ST_SEEK_KEY: begin
					state_d = sts.vocab_hit ? ST_SEEK_BRACE : ST_SEEK_KEY;
				end
				ST_SEEK_BRACE: begin
					state_d = sts.brace_hit ? ST_OBJECT : ST_SEEK_BRACE;
				end
				ST_OBJECT: begin
					if (sts.fire) begin
						state_d = sts.obj_end ? ST_EMIT_DONE : ST_EMIT;
					end else if (sts.obj_end) begin
						state_d = ST_DONE;
					end
				end
				ST_DONE: begin
					state_d = ST_DONE;
				end
				default: begin
					state_d = ST_SEEK_KEY;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SEEK_KEY;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### design/jves_dpath.sv
// Datapath of the JSON vocabulary entry scanner: byte parsing, key buffer and id.
// Depends on jves_pkg; steered by jves_ctrl through the command struct.
module jves_dpath #(
	parameter int TOKEN_BYTES = 32,
	parameter int MAX_NEST    = 255
) (
	input  logic                clk,
	input  logic                arst_n,
	input  jves_pkg::jves_cmd_t cmd,
	output jves_pkg::jves_sts_t sts,
	input  logic [7:0]          data_byte,
	output logic [7:0]          token_byte,
	output logic [63:0]         token_id,
	output logic                last_byte,
	output logic                truncated
);

	localparam int IW = (TOKEN_BYTES > 1) ? $clog2(TOKEN_BYTES) : 1;
	localparam int LW = $clog2(TOKEN_BYTES + 1);
	localparam int DW = (MAX_NEST > 1) ? $clog2(MAX_NEST + 1) : 1;

	logic [7:0]    buf_mem [TOKEN_BYTES];
	logic [7:0]    rdata_q;

	logic [2:0]    match_q, match_d, cur_match;
	logic [DW-1:0] depth_q, depth_d, cur_depth;
	logic          str_q, str_d, cur_str;
	logic          key_q, key_d, cur_key;
	logic          esc_q, esc_d, cur_esc;
	logic [LW-1:0] len_q, len_d, cur_len;
	logic          tovf_q, tovf_d, cur_tovf;
	logic [63:0]   idv_q, idv_d, cur_idv;
	logic [2:0]    ids_q, ids_d, cur_ids;
	logic          neg_q, neg_d, cur_neg;
	logic          iovf_q, iovf_d, cur_iovf;

	logic          append, feed, wr_en, fire, obj_end, vocab_hit, brace_hit, new_str;
	logic          is_digit;
	logic [3:0]    dig;
	logic [63:0]   idv_x10;
	logic [IW-1:0] wr_addr, rd_addr;

	logic [IW-1:0] ptr_q;
	logic [LW-1:0] emit_len_q;
	logic [63:0]   emit_id_q;
	logic          emit_trunc_q;
	logic          last;

	assign is_digit = (data_byte >= jves_pkg::CH_ZERO) && (data_byte <= jves_pkg::CH_NINE);
	assign dig      = data_byte[3:0] - jves_pkg::CH_ZERO[3:0];
	assign wr_addr  = cur_len[IW-1:0];

	always_comb begin
		// A new document sees every parse register at its reset value.
		cur_match = cmd.clr ? 3'd0 : match_q;
		cur_depth = cmd.clr ? '0 : depth_q;
		cur_str   = cmd.clr ? 1'b0 : str_q;
		cur_key   = cmd.clr ? 1'b0 : key_q;
		cur_esc   = cmd.clr ? 1'b0 : esc_q;
		cur_len   = cmd.clr ? '0 : len_q;
		cur_tovf  = cmd.clr ? 1'b0 : tovf_q;
		cur_idv   = cmd.clr ? 64'd0 : idv_q;
		cur_ids   = cmd.clr ? jves_pkg::ID_EMPTY : ids_q;
		cur_neg   = cmd.clr ? 1'b0 : neg_q;
		cur_iovf  = cmd.clr ? 1'b0 : iovf_q;
		idv_x10   = (cur_idv << 3) + (cur_idv << 1);

		match_d = cur_match;
		depth_d = cur_depth;
		str_d   = cur_str;
		key_d   = cur_key;
		esc_d   = cur_esc;
		len_d   = cur_len;
		tovf_d  = cur_tovf;
		idv_d   = cur_idv;
		ids_d   = cur_ids;
		neg_d   = cur_neg;
		iovf_d  = cur_iovf;

		append    = 1'b0;
		feed      = 1'b0;
		wr_en     = 1'b0;
		fire      = 1'b0;
		obj_end   = 1'b0;
		vocab_hit = 1'b0;
		brace_hit = 1'b0;
		new_str   = !cur_str;

		if (cmd.seek_key) begin
			if (data_byte == jves_pkg::vocab_char(cur_match)) begin
				if (cur_match + 3'd1 == jves_pkg::VOCAB_LEN) begin
					vocab_hit = 1'b1;
					match_d   = 3'd0;
				end else begin
					match_d = cur_match + 3'd1;
				end
			end else begin
				match_d = (data_byte == jves_pkg::CH_QUOTE) ? 3'd1 : 3'd0;
			end
		end

		if (cmd.seek_brace && (data_byte == jves_pkg::CH_LBRACE)) begin
			brace_hit = 1'b1;
			depth_d   = DW'(1);
		end

		if (cmd.object) begin
			if (cur_esc) begin
				append = cur_str && cur_key;
				esc_d  = 1'b0;
			end else if (data_byte == jves_pkg::CH_BSLASH) begin
				esc_d  = 1'b1;
				append = cur_str && cur_key;
				feed   = cur_str && !cur_key;
			end else if (data_byte == jves_pkg::CH_QUOTE) begin
				str_d = new_str;
				if (new_str && !cur_key && (cur_len == '0)) begin
					key_d = 1'b1;
				end else if (!new_str && cur_key) begin
					key_d = 1'b0;
				end
			end else if (cur_str) begin
				append = cur_key;
			end else if (is_digit || (data_byte == jves_pkg::CH_MINUS)) begin
				feed = 1'b1;
			end else if ((data_byte == jves_pkg::CH_COMMA) ||
			             (data_byte == jves_pkg::CH_RBRACE)) begin
				fire = (cur_len != '0) && !cur_iovf &&
				       ((cur_ids == jves_pkg::ID_DIGITS) || (cur_ids == jves_pkg::ID_ENDED));
				len_d  = '0;
				tovf_d = 1'b0;
				idv_d  = 64'd0;
				ids_d  = jves_pkg::ID_EMPTY;
				neg_d  = 1'b0;
				iovf_d = 1'b0;
				if (data_byte == jves_pkg::CH_RBRACE) begin
					if (cur_depth != '0) begin
						depth_d = cur_depth - DW'(1);
					end
					obj_end = (cur_depth == '0) || (cur_depth == DW'(1));
				end
			end else if (data_byte == jves_pkg::CH_LBRACE) begin
				if (cur_depth < DW'(MAX_NEST)) begin
					depth_d = cur_depth + DW'(1);
				end
			end
		end

		if (append) begin
			if (cur_len < LW'(TOKEN_BYTES)) begin
				wr_en = 1'b1;
				len_d = cur_len + LW'(1);
			end else begin
				tovf_d = 1'b1;
			end
		end

		if (feed) begin
			case (cur_ids)
				jves_pkg::ID_EMPTY: begin
					if (is_digit) begin
						idv_d = {60'd0, dig};
						ids_d = jves_pkg::ID_DIGITS;
					end else if (data_byte == jves_pkg::CH_MINUS) begin
						neg_d = 1'b1;
						ids_d = jves_pkg::ID_SIGN;
					end else begin
						ids_d = jves_pkg::ID_BAD;
					end
				end
				jves_pkg::ID_SIGN: begin
					if (is_digit) begin
						idv_d = {60'd0, dig};
						ids_d = jves_pkg::ID_DIGITS;
					end else begin
						ids_d = jves_pkg::ID_BAD;
					end
				end
				jves_pkg::ID_DIGITS: begin
					if (is_digit) begin
						if ((cur_idv > jves_pkg::ID_MAX_DIV10) ||
						    ((cur_idv == jves_pkg::ID_MAX_DIV10) &&
						     (dig > jves_pkg::ID_MAX_MOD10))) begin
							iovf_d = 1'b1;
						end else begin
							idv_d = idv_x10 + {60'd0, dig};
						end
					end else begin
						ids_d = jves_pkg::ID_ENDED;
					end
				end
				default: begin
					ids_d = cur_ids;
				end
			endcase
		end
	end

	// Emission side: the key buffer is read one byte ahead of the output.
	assign last = (LW'(ptr_q) + LW'(1)) == emit_len_q;

	always_comb begin
		if (!cmd.emit) begin
			rd_addr = '0;
		end else if (cmd.emit_adv) begin
			rd_addr = ptr_q + IW'(1);
		end else begin
			rd_addr = ptr_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			buf_mem[wr_addr] <= data_byte;
		end
		rdata_q <= buf_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.take && fire) begin
			emit_len_q   <= cur_len;
			emit_id_q    <= cur_neg ? (64'd0 - cur_idv) : cur_idv;
			emit_trunc_q <= cur_tovf;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 3'd0;
			depth_q <= '0;
			str_q   <= 1'b0;
			key_q   <= 1'b0;
			esc_q   <= 1'b0;
			len_q   <= '0;
			tovf_q  <= 1'b0;
			idv_q   <= 64'd0;
			ids_q   <= jves_pkg::ID_EMPTY;
			neg_q   <= 1'b0;
			iovf_q  <= 1'b0;
			ptr_q   <= '0;
		end else begin
			if (cmd.take) begin
				match_q <= match_d;
				depth_q <= depth_d;
				str_q   <= str_d;
				key_q   <= key_d;
				esc_q   <= esc_d;
				len_q   <= len_d;
				tovf_q  <= tovf_d;
				idv_q   <= idv_d;
				ids_q   <= ids_d;
				neg_q   <= neg_d;
				iovf_q  <= iovf_d;
			end
			if (cmd.emit_adv) begin
				ptr_q <= last ? '0 : ptr_q + IW'(1);
			end
		end
	end

	always_comb begin
		sts.vocab_hit = vocab_hit;
		sts.brace_hit = brace_hit;
		sts.fire      = fire;
		sts.obj_end   = obj_end;
		sts.emit_last = last;
	end

	assign token_byte = rdata_q;
	assign token_id   = emit_id_q;
	assign last_byte  = last;
	assign truncated  = emit_trunc_q;

endmodule

### design/json_vocab_entry_scanner.sv
// Top level of the JSON vocabulary entry scanner: stream ports, controller and datapath.
// Depends on jves_pkg, jves_ctrl and jves_dpath.
//
// Channel   Direction  Request carries
// s_*       in         one document byte (tdata) and the new-document flag (tuser)
// m_*       out        one token byte and its id (tdata), last byte (tlast), truncation (tuser)
//
// Document bytes are parsed as they are taken, back to back, while no token run is pending.
// A comma or closing brace that ends a valid entry starts a run of one output
// request per buffered key byte; input is held off until the final byte of the
// run is taken, so an entry with an N-byte key holds the input while its N requests
// go out, plus any output stall. The run is paced by the single read port of the key buffer.
// Reset returns the scanner to searching for the quoted word "vocab".
module json_vocab_entry_scanner #(
	parameter int TOKEN_BYTES = 32,
	parameter int MAX_NEST    = 255
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // [0] doc_start
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // [7:0] token_byte, [71:8] token_id
	output logic        m_tlast,   // last_byte
	output logic        m_tuser    // [0] truncated
);

	jves_pkg::jves_cmd_t cmd;
	jves_pkg::jves_sts_t sts;
	logic [7:0]          token_byte;
	logic [63:0]         token_id;

	// The controller owns the parse phase and decides when input is taken
	// and when a token run is on the output.
	jves_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_start  (s_tuser),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// The datapath holds string, key and escape state, the brace depth, the
	// key buffer and the id accumulator, and presents the run being sent.
	jves_dpath #(
		.TOKEN_BYTES (TOKEN_BYTES),
		.MAX_NEST    (MAX_NEST)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.data_byte  (s_tdata),
		.token_byte (token_byte),
		.token_id   (token_id),
		.last_byte  (m_tlast),
		.truncated  (m_tuser)
	);

	assign m_tdata = {token_id, token_byte};

endmodule

### design/jves_checker.sv
// Port-level checker for the JSON vocabulary entry scanner, bound to the top level.
// Depends on json_vocab_entry_scanner_defines.svh for its assertion macros.
`include "json_vocab_entry_scanner_defines.svh"

module jves_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [71:0] m_tdata,
	input logic        m_tlast,
	input logic        m_tuser
);

	// No byte is taken while a token run is on the output.
	`JVES_ASSERT_NOW(a_no_input_while_emit, m_tvalid, !s_tready)

	// A stalled output request holds its contents.
	`JVES_ASSERT_NEXT(a_stall_holds, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))

	// The id stays the same over the whole run.
	`JVES_ASSERT_NEXT(a_id_steady, m_tvalid && m_tready && !m_tlast, m_tvalid && (m_tdata[71:8] == $past(m_tdata[71:8])))

	// A run ends after its final byte, and begins only after a byte was taken.
	`JVES_ASSERT_NEXT(a_run_ends, m_tvalid && m_tready && m_tlast, !m_tvalid)
	`JVES_ASSERT_NOW(a_run_cause, $rose(m_tvalid), $past(s_tvalid && s_tready))

endmodule

bind json_vocab_entry_scanner jves_checker u_jves_checker (.*);

### tb/jves_token_checker.sv
// Checker for the JSON vocabulary entry scanner: predicts the token requests from the
// document bytes taken on the input channel and compares them with the output channel.
// Depends on jves_pkg for the character codes and the id text states.
module jves_token_checker #(
	parameter int TOKEN_BYTES = 32,
	parameter int MAX_NEST    = 255
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // [0] doc_start
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [71:0] m_tdata,   // [7:0] token_byte, [71:8] token_id
	input  logic        m_tlast,   // last_byte
	input  logic        m_tuser,   // [0] truncated
	output int          mismatches,
	output int          outstanding
);
	timeunit 1ns;
	timeprecision 1ps;
	import jves_pkg::*;

	typedef enum logic [1:0] {SEEK_WORD, SEEK_OPEN, IN_OBJECT, FINISHED} scan_phase_t;

	typedef struct packed {
		logic [7:0]  tok;
		logic [63:0] id;
		logic        last;
		logic        cut;
	} token_req_t;

	// The quoted word, first character in the top byte.
	localparam logic [55:0] VOCAB_WORD = "\"vocab\"";

	scan_phase_t phase_q;
	logic [2:0]  word_pos;
	int          depth;
	logic        in_str;
	logic        in_key;
	logic        esc;
	logic [7:0]  key_buf [TOKEN_BYTES];
	int          key_len;
	logic        key_cut;
	logic [63:0] id_acc;
	logic [2:0]  id_state;
	logic        id_neg;
	logic        id_ovf;
	token_req_t  expected_tokens [$];
	int          fail_n;

	task automatic clear_entry();
		key_len = 0;
		key_cut = 1'b0;
		id_acc = '0;
		id_state = ID_EMPTY;
		id_neg = 1'b0;
		id_ovf = 1'b0;
	endtask

	task automatic clear_scan();
		phase_q = SEEK_WORD;
		word_pos = '0;
		depth = 0;
		in_str = 1'b0;
		in_key = 1'b0;
		esc = 1'b0;
		clear_entry();
	endtask

	task automatic append_key(input logic [7:0] b);
		if (key_len < TOKEN_BYTES) begin
			key_buf[key_len] = b;
			key_len++;
		end else begin
			key_cut = 1'b1;
		end
	endtask

	// Decimal id text with the usual string-to-unsigned rules.
	task automatic feed_id(input logic [7:0] b);
		logic        dig;
		logic [67:0] nxt;
		dig = (b >= CH_ZERO) && (b <= CH_NINE);
		nxt = {4'd0, id_acc} * 68'd10 + {64'd0, b[3:0]};
		case (id_state)
			ID_EMPTY: begin
				if (dig) begin
					id_acc = {60'd0, b[3:0]};
					id_state = ID_DIGITS;
				end else if (b == CH_MINUS) begin
					id_neg = 1'b1;
					id_state = ID_SIGN;
				end else begin
					id_state = ID_BAD;
				end
			end
			ID_SIGN: begin
				if (dig) begin
					id_acc = {60'd0, b[3:0]};
					id_state = ID_DIGITS;
				end else begin
					id_state = ID_BAD;
				end
			end
			ID_DIGITS: begin
				if (!dig)
					id_state = ID_ENDED;
				else if (nxt[67:64] != 4'd0)
					id_ovf = 1'b1;
				else
					id_acc = nxt[63:0];
			end
			default: ;
		endcase
	endtask

	task automatic parse_doc_byte(input logic [7:0] b, input logic start);
		logic        dig;
		int          k;
		logic [63:0] id_out;
		token_req_t  r;
		dig = (b >= CH_ZERO) && (b <= CH_NINE);
		if (start)
			clear_scan();
		k = word_pos;
		case (phase_q)
			SEEK_WORD: begin
				if (b == VOCAB_WORD[55 - 8 * k -: 8]) begin
					word_pos = word_pos + 3'd1;
					if (word_pos == VOCAB_LEN) begin
						phase_q = SEEK_OPEN;
						word_pos = '0;
					end
				end else begin
					word_pos = (b == CH_QUOTE) ? 3'd1 : 3'd0;
				end
			end
			SEEK_OPEN: begin
				if (b == CH_LBRACE) begin
					phase_q = IN_OBJECT;
					depth = 1;
				end
			end
			IN_OBJECT: begin
				if (esc) begin
					if (in_str && in_key)
						append_key(b);
					esc = 1'b0;
				end else if (b == CH_BSLASH) begin
					esc = 1'b1;
					if (in_str) begin
						if (in_key)
							append_key(b);
						else
							feed_id(b);
					end
				end else if (b == CH_QUOTE) begin
					in_str = !in_str;
					if (in_str && !in_key && key_len == 0)
						in_key = 1'b1;
					else if (!in_str && in_key)
						in_key = 1'b0;
				end else if (in_str) begin
					if (in_key)
						append_key(b);
				end else if (dig || b == CH_MINUS) begin
					feed_id(b);
				end else if (b == CH_COMMA || b == CH_RBRACE) begin
					if (key_len != 0 && (id_state == ID_DIGITS || id_state == ID_ENDED)
							&& !id_ovf) begin
						id_out = id_neg ? (64'd0 - id_acc) : id_acc;
						for (int i = 0; i < key_len; i++) begin
							r.tok = key_buf[i];
							r.id = id_out;
							r.last = (i + 1 == key_len);
							r.cut = key_cut;
							expected_tokens.push_back(r);
						end
					end
					clear_entry();
					if (b == CH_RBRACE) begin
						if (depth > 0)
							depth--;
						if (depth == 0)
							phase_q = FINISHED;
					end
				end else if (b == CH_LBRACE) begin
					if (depth < MAX_NEST)
						depth++;
				end
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		token_req_t want;
		token_req_t got;
		if (!arst_n) begin
			clear_scan();
			expected_tokens.delete();
			fail_n = 0;
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			// Outputs first: a request leaving now was predicted at an earlier edge.
			if (m_tvalid && m_tready) begin
				got = {m_tdata[7:0], m_tdata[71:8], m_tlast, m_tuser};
				if (expected_tokens.size() == 0) begin
					fail_n++;
					$display("%0t: token request with none expected", $time,
						", actual byte %h id %h last %b cut %b",
						got.tok, got.id, got.last, got.cut);
				end else begin
					want = expected_tokens.pop_front();
					if (got !== want) begin
						fail_n++;
						$display("%0t: token mismatch", $time,
							", expected byte %h id %h last %b cut %b",
							want.tok, want.id, want.last, want.cut,
							", actual byte %h id %h last %b cut %b",
							got.tok, got.id, got.last, got.cut);
					end
				end
			end
			if (s_tvalid && s_tready)
				parse_doc_byte(s_tdata, s_tuser);
			mismatches <= fail_n;
			outstanding <= expected_tokens.size();
		end
	end

endmodule

### tb/tb_json_vocab_entry_scanner.sv
// Top of the testbench for the JSON vocabulary entry scanner: clock, reset, document
// stimulus and the verdict. Depends on jves_pkg, jves_token_checker and the scanner itself.
module tb_json_vocab_entry_scanner;
	timeunit 1ns;
	timeprecision 1ps;
	import jves_pkg::*;

	localparam int TOKEN_BYTES  = 32;
	localparam int MAX_NEST     = 255;
	// Input requests to send in all; the last document may run a little past it.
	localparam int ITEM_TARGET  = 160;
	// Cycles allowed for the whole run; the slowest correct run needs far fewer.
	localparam int CYCLE_LIMIT  = 10000;
	// Quiet cycles after the last expected token, well past the parse latency.
	localparam int DRAIN_CYCLES = 16;
	localparam logic [7:0] CH_SPACE = 8'h20;

	typedef enum logic [1:0] {FLOW_FREE, FLOW_SEND_GAPS, FLOW_RECV_STALL, FLOW_BOTH} flow_mode_t;
	typedef enum {KEY_NONE, KEY_SHORT, KEY_LONG} key_kind_t;
	typedef enum {VAL_NONE, VAL_SMALL, VAL_NEG, VAL_WIDE, VAL_MAX, VAL_OVER, VAL_JUNK,
		VAL_STRING, VAL_NEST} val_kind_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [71:0] m_tdata;
	logic        m_tlast;
	logic        m_tuser;
	int          mismatches;
	int          outstanding;

	int unsigned cycle_count = 0;
	int          send_gap_pct = 0;   // read only by the stimulus process
	int          stall_pct = 0;      // read by the receiver process, written by NBA
	int          bytes_sent = 0;
	logic        start_pending;
	// Each entry holds {doc_start, data_byte} of one input request.
	logic [8:0]  doc_bytes [$];

	json_vocab_entry_scanner #(
		.TOKEN_BYTES(TOKEN_BYTES),
		.MAX_NEST(MAX_NEST)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.m_tuser(m_tuser)
	);

	jves_token_checker #(
		.TOKEN_BYTES(TOKEN_BYTES),
		.MAX_NEST(MAX_NEST)
	) token_check (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.m_tuser(m_tuser),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// The receiver stalls at random according to the current flow mode; with a zero
	// percentage it takes every output request at once.
	always @(posedge clk) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= ($urandom_range(99) >= stall_pct);
	end

	// Watchdog: a hung scanner must still end the run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic logic [7:0] any_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	// A key character that neither closes the string nor starts an escape.
	function automatic logic [7:0] key_char();
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (b == CH_QUOTE || b == CH_BSLASH);
		return b;
	endfunction

	// The first byte queued after start_pending is set carries the new-document flag.
	task automatic put_byte(input logic [7:0] b);
		doc_bytes.push_back({start_pending, b});
		start_pending = 1'b0;
	endtask

	task automatic put_text(input string s);
		for (int i = 0; i < s.len(); i++)
			put_byte(s[i]);
	endtask

	// Gap percentage for the sender and stall percentage for the receiver.
	task automatic set_flow(input flow_mode_t mode);
		send_gap_pct = (mode == FLOW_SEND_GAPS) ? 65 : (mode == FLOW_BOTH) ? 36 : 0;
		stall_pct <= (mode == FLOW_RECV_STALL) ? 65 : (mode == FLOW_BOTH) ? 36 : 0;
	endtask

	// One "key":value pair, without its separator.
	task automatic put_entry(input key_kind_t kk, input val_kind_t vk);
		int          klen;
		logic [63:0] wide;
		if (kk == KEY_NONE)
			klen = 0;
		else if (kk == KEY_LONG)
			klen = $urandom_range(TOKEN_BYTES - 1, TOKEN_BYTES + 4);
		else
			klen = $urandom_range(1, 5);
		put_byte(CH_QUOTE);
		for (int j = 0; j < klen; j++) begin
			// An escape pair puts both bytes into the key, whatever the second one is.
			if ($urandom_range(0, 7) == 0) begin
				put_byte(CH_BSLASH);
				put_byte(any_byte());
			end else begin
				put_byte(key_char());
			end
		end
		put_byte(CH_QUOTE);
		put_text(":");
		if ($urandom_range(0, 3) == 0)
			put_byte(CH_SPACE);
		case (vk)
			VAL_NONE: ;
			VAL_SMALL: put_text($sformatf("%0d", $urandom_range(0, 99999)));
			VAL_NEG: put_text($sformatf("-%0d", $urandom_range(0, 99999)));
			VAL_WIDE: begin
				wide = {$urandom, $urandom};
				put_text($sformatf("%0d", wide));
			end
			VAL_MAX: put_text("18446744073709551615");
			VAL_OVER: begin
				if ($urandom_range(0, 1) == 0)
					put_text("18446744073709551616");
				else
					put_text("99999999999999999999");
			end
			VAL_JUNK: begin
				// Letters outside strings are skipped, a second minus spoils the id.
				case ($urandom_range(0, 3))
					0: put_text("12a3");
					1: put_text("--4");
					2: put_text("-x");
					default: put_text("7-2");
				endcase
			end
			VAL_STRING: begin
				// A value string; a backslash inside it counts as a non-digit.
				put_byte(CH_QUOTE);
				repeat ($urandom_range(0, 3))
					put_byte(key_char());
				if ($urandom_range(0, 2) == 0) begin
					put_byte(CH_BSLASH);
					put_byte(any_byte());
				end
				put_byte(CH_QUOTE);
				if ($urandom_range(0, 1) == 0)
					put_text($sformatf("%0d", $urandom_range(0, 999)));
			end
			default: begin
				// A nested object; its closing brace ends the entry in progress.
				put_byte(CH_LBRACE);
				put_byte(CH_QUOTE);
				put_byte(key_char());
				put_byte(CH_QUOTE);
				put_text($sformatf(":%0d", $urandom_range(0, 999)));
				put_byte(CH_RBRACE);
			end
		endcase
	endtask

	// A whole document: some noise, the quoted word, the object and its entries.
	// When forced is set the entries take the long-key and extreme-id cases.
	task automatic build_doc(input logic forced);
		int        n_ent;
		int        r;
		key_kind_t kk;
		val_kind_t vk;
		start_pending = 1'b1;
		repeat ($urandom_range(0, 2))
			put_byte(any_byte());
		if ($urandom_range(0, 5) == 0)
			put_text("\"voc");
		// A near miss of the word leaves the whole document ignored.
		if (!forced && $urandom_range(0, 9) == 0)
			put_text("\"vocal\"");
		else
			put_text("\"vocab\"");
		put_text(":");
		if ($urandom_range(0, 1) == 0)
			put_byte(CH_SPACE);
		put_byte(CH_LBRACE);
		n_ent = forced ? 3 : $urandom_range(1, 4);
		for (int k = 0; k < n_ent; k++) begin
			if (forced) begin
				kk = (k == 0) ? KEY_LONG : KEY_SHORT;
				vk = (k == 0) ? VAL_MAX : (k == 1) ? VAL_OVER : VAL_NEG;
			end else begin
				r = $urandom_range(0, 19);
				kk = (r == 0) ? KEY_NONE : (r == 1) ? KEY_LONG : KEY_SHORT;
				case ($urandom_range(0, 15))
					0: vk = VAL_NONE;
					6, 7: vk = VAL_NEG;
					8: vk = VAL_MAX;
					9: vk = VAL_OVER;
					10, 11: vk = VAL_WIDE;
					12: vk = VAL_JUNK;
					13: vk = VAL_STRING;
					14: vk = VAL_NEST;
					default: vk = VAL_SMALL;
				endcase
			end
			put_entry(kk, vk);
			// Now and then the document breaks off; the next doc_start must recover.
			if (!forced && $urandom_range(0, 11) == 0)
				return;
			if (k < n_ent - 1) begin
				put_byte(CH_COMMA);
			end else if ($urandom_range(0, 7) == 0) begin
				put_byte(CH_COMMA);
				put_byte(CH_SPACE);
				put_byte(CH_RBRACE);
			end else begin
				put_byte(CH_RBRACE);
			end
		end
		// Anything after the object must be ignored.
		if ($urandom_range(0, 2) == 0)
			put_text("\"z\":1,}");
	endtask

	// Sends the queued bytes, one input request each, with idle gaps before a request
	// as the flow mode asks. A request is taken at the edge where tvalid and tready meet.
	task automatic send_doc_bytes();
		logic [8:0] entry;
		int         mode_idx;
		while (doc_bytes.size() != 0) begin
			entry = doc_bytes.pop_front();
			// The flow mode steps through its four settings over the whole run.
			mode_idx = (bytes_sent * 4) / ITEM_TARGET;
			if (mode_idx > 3)
				mode_idx = 3;
			set_flow(flow_mode_t'(mode_idx));
			while ($urandom_range(99) < send_gap_pct) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
			s_tvalid <= 1'b1;
			s_tdata <= entry[7:0];
			s_tuser <= entry[8];
			@(posedge clk);
			while (!s_tready)
				@(posedge clk);
			bytes_sent++;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = 8'h00;
		s_tuser = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed document: lowest and highest byte values, an escaped quote and a byte
		// above 127 inside a key, a negative id that wraps to the top value, an empty key,
		// a minus zero id that comes out as zero, an empty id on the closing brace, and a
		// byte after the object.
		start_pending = 1'b1;
		put_byte(8'h00);
		put_text("\"vocab\"");
		put_byte(CH_LBRACE);
		put_byte(CH_QUOTE);
		put_byte(CH_BSLASH);
		put_byte(CH_QUOTE);
		put_byte(8'hFF);
		put_byte(CH_QUOTE);
		put_text(":-1,");
		put_text("\"\":5,");
		put_text("\"m\":-0,");
		put_text("\"x\":}");
		put_byte(8'hFF);
		send_doc_bytes();

		// A key around the buffer size with the largest id, an overflowing id and a
		// negative one.
		build_doc(1'b1);
		send_doc_bytes();

		// Random documents until the planned number of requests has gone out.
		while (bytes_sent < ITEM_TARGET) begin
			build_doc(1'b0);
			send_doc_bytes();
		end

		// Let the checker's counters catch up before relying on them.
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

### files.f
+incdir+design
design/jves_pkg.sv
design/jves_ctrl.sv
design/jves_dpath.sv
design/json_vocab_entry_scanner.sv
design/jves_checker.sv
tb/jves_token_checker.sv
tb/tb_json_vocab_entry_scanner.sv
